FILE: src/ppstd_pkg.sv
package ppstd_pkg;

   typedef enum logic {
      OP_PULSE = 1'b0,
      OP_TIME  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CSR_DEBOUNCE     = 2'd0,
      CSR_MAX_INTERVAL = 2'd1,
      CSR_WINDOW_LOW   = 2'd2,
      CSR_WINDOW_HIGH  = 2'd3
   } csr_index_type;

   localparam logic [31:0] DEBOUNCE_RESET     = 32'd500000;
   localparam logic [31:0] MAX_INTERVAL_RESET = 32'd1500000;
   localparam logic [31:0] WINDOW_LOW_RESET   = 32'd300000;
   localparam logic [31:0] WINDOW_HIGH_RESET  = 32'd700999;

   localparam logic [11:0] YEAR_BASE     = 12'd1900;
   localparam logic [12:0] DIV100_MUL    = 13'd5243;
   localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
   localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
   localparam logic [31:0] SECS_PER_MIN  = 32'd60;

   typedef struct packed {
      op_type      op;
      logic [31:0] timestamp_us;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  sec;
   } item_type;

   // Quotients of the calendar formula, one stage after the input register.
   typedef struct packed {
      op_type             op;
      logic [31:0]        timestamp_us;
      logic [11:0]        year;
      logic [5:0]         year_q100;
      logic signed [13:0] y;
      logic signed [10:0] t4;
      logic signed [6:0]  t100;
      logic signed [4:0]  t400;
      logic [3:0]         month;
      logic [4:0]         day;
      logic [4:0]         hour;
      logic [5:0]         minute;
      logic [5:0]         sec;
   } quot_type;

   typedef struct packed {
      op_type             op;
      logic [31:0]        timestamp_us;
      logic signed [21:0] days;
      logic [4:0]         hour;
      logic [5:0]         minute;
      logic [5:0]         sec;
   } days_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] timestamp_us;
      logic [31:0] unix_value;
   } event_type;

   typedef struct packed {
      logic [31:0] unix_seconds;
      logic [31:0] interval_us;
      logic [31:0] pulse_count;
      logic        pulse_accepted;
      logic        time_loaded;
      logic        pulse_seen;
   } result_type;

   // Floor division by 100 for values below 4096 by a reciprocal multiply.
   function automatic logic [5:0] div100(input logic [11:0] x);
      logic [24:0] prod;
      prod = 25'(x) * 25'(DIV100_MUL);
      return prod[24:19];
   endfunction

   function automatic logic [13:0] magnitude(input logic signed [13:0] a);
      logic [13:0] m;
      m = a[13] ? (~a + 14'd1) : a;
      return m;
   endfunction

   // Signed divisions truncating toward zero.
   function automatic logic signed [10:0] tdiv4(input logic signed [13:0] a);
      logic [13:0] m;
      logic [10:0] q;
      m = magnitude(a);
      q = m[12:2];
      return a[13] ? signed'(~q + 11'd1) : signed'(q);
   endfunction

   function automatic logic signed [6:0] tdiv100(input logic signed [13:0] a);
      logic [13:0] m;
      logic [6:0]  q;
      m = magnitude(a);
      q = {1'b0, div100(m[11:0])};
      return a[13] ? signed'(~q + 7'd1) : signed'(q);
   endfunction

   function automatic logic signed [4:0] tdiv400(input logic signed [13:0] a);
      logic [13:0] m;
      logic [5:0]  q100;
      logic [4:0]  q;
      m = magnitude(a);
      q100 = div100(m[11:0]);
      q = {1'b0, q100[5:2]};
      return a[13] ? signed'(~q + 5'd1) : signed'(q);
   endfunction

   // Days in the months before the given one of a common year.
   // Month zero adds nothing; months above twelve add the whole year.
   function automatic logic [8:0] days_before_month(input logic [3:0] month);
      logic [8:0] d;
      case (month)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd365;
      endcase
      return d;
   endfunction

endpackage

FILE: src/ppstd_date_conv.sv
module ppstd_date_conv (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ppstd_pkg::item_type   in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ppstd_pkg::event_type  out_event
);

   ppstd_pkg::item_type  item_ff;
   ppstd_pkg::quot_type  quot_ff, quot_in;
   ppstd_pkg::days_type  days_ff, days_in;
   ppstd_pkg::event_type evt_ff, evt_in;

   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic ld0, ld1, ld2, ld3;

   // Each stage loads when it is empty or its content moves on.
   assign ld3 = !v3_ff || out_ready;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;
   assign ld0 = !v0_ff || ld1;

   assign in_ready  = ld0;
   assign out_valid = v3_ff;
   assign out_event = evt_ff;

   // Stage 1: year offset and the truncated quotients.
   always_comb begin
      logic signed [13:0] y;
      y = signed'(14'(item_ff.year) - 14'(ppstd_pkg::YEAR_BASE));
      quot_in.op           = item_ff.op;
      quot_in.timestamp_us = item_ff.timestamp_us;
      quot_in.year         = item_ff.year;
      quot_in.year_q100    = ppstd_pkg::div100(item_ff.year);
      quot_in.y            = y;
      quot_in.t4           = ppstd_pkg::tdiv4(y - 14'sd69);
      quot_in.t100         = ppstd_pkg::tdiv100(y - 14'sd1);
      quot_in.t400         = ppstd_pkg::tdiv400(y + 14'sd299);
      quot_in.month        = item_ff.month;
      quot_in.day          = item_ff.day;
      quot_in.hour         = item_ff.hour;
      quot_in.minute       = item_ff.minute;
      quot_in.sec          = item_ff.sec;
   end

   // Stage 2: day count since the epoch.
   always_comb begin
      logic               leap;
      logic [11:0]        q_times_100;
      logic signed [21:0] yy;
      logic signed [21:0] month_days;
      q_times_100 = 12'(quot_ff.year_q100) * 12'd100;
      leap = (quot_ff.year[1:0] == 2'd0)
             && ((q_times_100 != quot_ff.year) || (quot_ff.year_q100[1:0] == 2'd0));
      yy = 22'(quot_ff.y);
      month_days = signed'(22'(ppstd_pkg::days_before_month(quot_ff.month)))
                   + ((leap && (quot_ff.month >= 4'd3)) ? 22'sd1 : 22'sd0);
      days_in.op           = quot_ff.op;
      days_in.timestamp_us = quot_ff.timestamp_us;
      days_in.days         = (yy - 22'sd70) * 22'sd365
                             + 22'(quot_ff.t4) - 22'(quot_ff.t100) + 22'(quot_ff.t400)
                             + month_days
                             + signed'(22'(quot_ff.day)) - 22'sd1;
      days_in.hour         = quot_ff.hour;
      days_in.minute       = quot_ff.minute;
      days_in.sec          = quot_ff.sec;
   end

   // Stage 3: seconds, modulo 2^32.
   always_comb begin
      evt_in.op           = days_ff.op;
      evt_in.timestamp_us = days_ff.timestamp_us;
      evt_in.unix_value   = 32'(days_ff.days) * ppstd_pkg::SECS_PER_DAY
                            + 32'(days_ff.hour) * ppstd_pkg::SECS_PER_HOUR
                            + 32'(days_ff.minute) * ppstd_pkg::SECS_PER_MIN
                            + 32'(days_ff.sec);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ld0) v0_ff <= in_valid;
         if (ld1) v1_ff <= v0_ff;
         if (ld2) v2_ff <= v1_ff;
         if (ld3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld0) item_ff <= in_item;
      if (ld1) quot_ff <= quot_in;
      if (ld2) days_ff <= days_in;
      if (ld3) evt_ff  <= evt_in;
   end

endmodule

FILE: src/ppstd_discipline.sv
module ppstd_discipline (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ppstd_pkg::event_type  in_event,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ppstd_pkg::result_type out_result
);

   logic [31:0] debounce_ff, max_interval_ff, window_low_ff, window_high_ff;

   logic [31:0] last_edge_ff, last_edge_in;
   logic        seen_ff, seen_in;
   logic [31:0] interval_ff, interval_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] seconds_ff, seconds_in;
   logic [31:0] last_loaded_ff, last_loaded_in;

   ppstd_pkg::result_type result_ff, result_in;
   logic                  rvalid_ff;
   logic                  ld, fire;
   logic                  accepted, loaded;
   logic [31:0]           gap;

   assign ld        = !rvalid_ff || out_ready;
   assign in_ready  = ld;
   assign fire      = in_valid && ld;
   assign out_valid = rvalid_ff;
   assign out_result = result_ff;

   // Age of the event since the last accepted edge, modulo 2^32.
   assign gap = in_event.timestamp_us - last_edge_ff;

   always_comb begin
      last_edge_in   = last_edge_ff;
      seen_in        = seen_ff;
      interval_in    = interval_ff;
      count_in       = count_ff;
      seconds_in     = seconds_ff;
      last_loaded_in = last_loaded_ff;
      accepted       = 1'b0;
      loaded         = 1'b0;
      if (fire) begin
         case (in_event.op)
            ppstd_pkg::OP_PULSE: begin
               if (!seen_ff || (gap >= debounce_ff)) begin
                  if (seen_ff && (gap < max_interval_ff)) begin
                     interval_in = gap;
                  end
                  last_edge_in = in_event.timestamp_us;
                  seen_in      = 1'b1;
                  count_in     = count_ff + 32'd1;
                  seconds_in   = seconds_ff + 32'd1;
                  accepted     = 1'b1;
               end
            end
            ppstd_pkg::OP_TIME: begin
               if (in_event.unix_value != 32'd0) begin
                  if (!seen_ff) begin
                     seconds_in = in_event.unix_value;
                     loaded     = 1'b1;
                  end else if ((gap >= window_low_ff) && (gap <= window_high_ff)
                               && (last_loaded_ff != in_event.unix_value)) begin
                     seconds_in     = in_event.unix_value;
                     last_loaded_in = in_event.unix_value;
                     loaded         = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      result_in.unix_seconds   = seconds_in;
      result_in.interval_us    = interval_in;
      result_in.pulse_count    = count_in;
      result_in.pulse_accepted = accepted;
      result_in.time_loaded    = loaded;
      result_in.pulse_seen     = seen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff     <= ppstd_pkg::DEBOUNCE_RESET;
         max_interval_ff <= ppstd_pkg::MAX_INTERVAL_RESET;
         window_low_ff   <= ppstd_pkg::WINDOW_LOW_RESET;
         window_high_ff  <= ppstd_pkg::WINDOW_HIGH_RESET;
      end else if (csr_we) begin
         case (ppstd_pkg::csr_index_type'(csr_index))
            ppstd_pkg::CSR_DEBOUNCE:     debounce_ff     <= csr_wdata;
            ppstd_pkg::CSR_MAX_INTERVAL: max_interval_ff <= csr_wdata;
            ppstd_pkg::CSR_WINDOW_LOW:   window_low_ff   <= csr_wdata;
            ppstd_pkg::CSR_WINDOW_HIGH:  window_high_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff   <= 32'd0;
         seen_ff        <= 1'b0;
         interval_ff    <= 32'd0;
         count_ff       <= 32'd0;
         seconds_ff     <= 32'd0;
         last_loaded_ff <= 32'd0;
         rvalid_ff      <= 1'b0;
      end else begin
         last_edge_ff   <= last_edge_in;
         seen_ff        <= seen_in;
         interval_ff    <= interval_in;
         count_ff       <= count_in;
         seconds_ff     <= seconds_in;
         last_loaded_ff <= last_loaded_in;
         if (ld) rvalid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) result_ff <= result_in;
   end

endmodule

FILE: src/pps_time_discipline.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    op, timestamp, date and time of a report
// rsp_      out        rsp_valid/rsp_ready    seconds, interval, count and status flags
// csr_      in         csr_we (no wait)       csr_index, csr_wdata
//
// One item is taken every cycle unless a stall on rsp_ holds the pipeline. The
// input, quotient, day-count and event registers convert the date to unix
// seconds, and a last stage applies it to the timing state and the result register.
// Reset (synchronous, active high) empties every stage, clears the state and
// restores the register defaults. A stall on rsp_ travels back stage by stage,
// so empty stages keep filling until the whole pipeline is full.
module pps_time_discipline (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [31:0] req_timestamp_us,
   input  logic [11:0] req_year,
   input  logic [3:0]  req_month,
   input  logic [4:0]  req_day,
   input  logic [4:0]  req_hour,
   input  logic [5:0]  req_minute,
   input  logic [5:0]  req_sec,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_unix_seconds,
   output logic [31:0] rsp_interval_us,
   output logic [31:0] rsp_pulse_count,
   output logic        rsp_pulse_accepted,
   output logic        rsp_time_loaded,
   output logic        rsp_pulse_seen
);

   ppstd_pkg::item_type   req_item;
   ppstd_pkg::event_type  evt;
   ppstd_pkg::result_type result;
   logic                  evt_valid;
   logic                  evt_ready;

   // Gather the request fields into one item for the conversion pipeline.
   assign req_item.op           = ppstd_pkg::op_type'(req_op);
   assign req_item.timestamp_us = req_timestamp_us;
   assign req_item.year         = req_year;
   assign req_item.month        = req_month;
   assign req_item.day          = req_day;
   assign req_item.hour         = req_hour;
   assign req_item.minute       = req_minute;
   assign req_item.sec          = req_sec;

   // Date-to-seconds conversion. Pulse edges pass through it unchanged so that
   // items keep their order on the way to the state stage.
   ppstd_date_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .out_valid (evt_valid),
      .out_ready (evt_ready),
      .out_event (evt)
   );

   // Pulse qualification, seconds counter and the result register. All state
   // that an item reads is updated in the same cycle, so the next item sees it.
   ppstd_discipline u_disc (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_valid   (evt_valid),
      .in_ready   (evt_ready),
      .in_event   (evt),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (result)
   );

   assign rsp_unix_seconds   = result.unix_seconds;
   assign rsp_interval_us    = result.interval_us;
   assign rsp_pulse_count    = result.pulse_count;
   assign rsp_pulse_accepted = result.pulse_accepted;
   assign rsp_time_loaded    = result.time_loaded;
   assign rsp_pulse_seen     = result.pulse_seen;

endmodule
